@@ rtl/mvts_pkg.sv @@
package mvts_pkg;

  localparam logic [15:0] TICKS_PER_MINUTE = 16'd60000;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSAL_PAUSE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_PULSE  = 8'd1;

  localparam logic [15:0] REVERSAL_PAUSE_RST = 16'd1000;
  localparam logic [15:0] CONTROL_PULSE_RST  = 16'd10000;

  // drive_and_lamps bit positions
  localparam int DL_OPEN_DRIVE  = 0;
  localparam int DL_CLOSE_DRIVE = 1;
  localparam int DL_OPEN_LAMP   = 2;
  localparam int DL_CLOSE_LAMP  = 3;

  localparam logic [3:0] DL_OPENED = 4'b0101;
  localparam logic [3:0] DL_CLOSED = 4'b1010;
  localparam logic [3:0] DL_DRIVES = 4'b0011;

  localparam logic [16:0] MAX17 = 17'h1FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        open_drive;
    logic        close_drive;
    logic        open_lamp;
    logic        close_lamp;
    logic        valve_is_open;
    logic [31:0] remaining;
  } result_t;

endpackage

@@ rtl/mvts_core.sv @@
module mvts_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [1:0]                    command,
  input  logic [15:0]                   duration_minutes,
  input  logic                          cfg_we,
  input  logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output mvts_pkg::result_t             result
);

  logic [15:0] pause_r;
  logic [15:0] pulse_r;

  logic        open_pending_r, open_pending_nxt;
  logic [31:0] open_elapsed_r, open_elapsed_nxt;
  logic [15:0] stored_duration_r, stored_duration_nxt;
  logic [31:0] span_r, span_nxt;
  logic        close_pending_r, close_pending_nxt;
  logic [16:0] close_elapsed_r, close_elapsed_nxt;
  logic        pulse_active_r, pulse_active_nxt;
  logic [16:0] pulse_elapsed_r, pulse_elapsed_nxt;
  logic        open_flag_r, open_flag_nxt;
  logic [3:0]  dl_r, dl_nxt;

  logic [31:0] product;
  logic [31:0] remaining;

  assign product = 32'(duration_minutes) * 32'(mvts_pkg::TICKS_PER_MINUTE);

  always_comb begin
    open_pending_nxt    = open_pending_r;
    open_elapsed_nxt    = open_elapsed_r;
    stored_duration_nxt = stored_duration_r;
    span_nxt            = span_r;
    close_pending_nxt   = close_pending_r;
    close_elapsed_nxt   = close_elapsed_r;
    pulse_active_nxt    = pulse_active_r;
    pulse_elapsed_nxt   = pulse_elapsed_r;
    open_flag_nxt       = open_flag_r;
    dl_nxt              = dl_r;
    unique case (command)
      mvts_pkg::CMD_TICK: begin
        if (open_pending_r && open_elapsed_r != mvts_pkg::MAX32) begin
          open_elapsed_nxt = open_elapsed_r + 32'd1;
        end
        if (close_pending_r && close_elapsed_r != mvts_pkg::MAX17) begin
          close_elapsed_nxt = close_elapsed_r + 17'd1;
        end
        if (pulse_active_r && pulse_elapsed_r != mvts_pkg::MAX17) begin
          pulse_elapsed_nxt = pulse_elapsed_r + 17'd1;
        end
        if (open_pending_r && open_elapsed_nxt > 32'(pause_r)) begin
          if (!open_flag_r) begin
            dl_nxt            = mvts_pkg::DL_OPENED;
            open_flag_nxt     = 1'b1;
            pulse_active_nxt  = 1'b1;
            pulse_elapsed_nxt = '0;
          end
          if (open_elapsed_nxt > span_r) begin
            dl_nxt            = mvts_pkg::DL_CLOSED;
            open_pending_nxt  = 1'b0;
            open_flag_nxt     = 1'b0;
            pulse_active_nxt  = 1'b1;
            pulse_elapsed_nxt = '0;
          end
        end
        if (close_pending_r && close_elapsed_nxt > 17'(pause_r)) begin
          close_pending_nxt = 1'b0;
          dl_nxt            = mvts_pkg::DL_CLOSED;
          open_pending_nxt  = 1'b0;
          open_flag_nxt     = 1'b0;
          pulse_active_nxt  = 1'b1;
          pulse_elapsed_nxt = '0;
        end
        if (pulse_active_nxt && pulse_elapsed_nxt > 17'(pulse_r)) begin
          dl_nxt           = dl_nxt & ~mvts_pkg::DL_DRIVES;
          pulse_active_nxt = 1'b0;
        end
      end
      mvts_pkg::CMD_OPEN: begin
        dl_nxt              = dl_r & ~mvts_pkg::DL_DRIVES;
        open_pending_nxt    = 1'b1;
        open_elapsed_nxt    = '0;
        stored_duration_nxt = duration_minutes;
        span_nxt            = product;
      end
      mvts_pkg::CMD_CLOSE: begin
        dl_nxt            = dl_r & ~mvts_pkg::DL_DRIVES;
        close_pending_nxt = 1'b1;
        close_elapsed_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // on an open word elapsed is zero, so the product is the remaining time
  always_comb begin
    if (command == mvts_pkg::CMD_OPEN) begin
      remaining = product;
    end else if (open_pending_nxt) begin
      remaining = (span_r > open_elapsed_nxt) ? span_r - open_elapsed_nxt : '0;
    end else begin
      remaining = 32'(stored_duration_r);
    end
  end

  always_comb begin
    result.open_drive    = dl_nxt[mvts_pkg::DL_OPEN_DRIVE];
    result.close_drive   = dl_nxt[mvts_pkg::DL_CLOSE_DRIVE];
    result.open_lamp     = dl_nxt[mvts_pkg::DL_OPEN_LAMP];
    result.close_lamp    = dl_nxt[mvts_pkg::DL_CLOSE_LAMP];
    result.valve_is_open = open_flag_nxt;
    result.remaining     = remaining;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r <= mvts_pkg::REVERSAL_PAUSE_RST;
      pulse_r <= mvts_pkg::CONTROL_PULSE_RST;
    end else if (cfg_we) begin
      if (cfg_index == mvts_pkg::CFG_REVERSAL_PAUSE) begin
        pause_r <= cfg_data;
      end
      if (cfg_index == mvts_pkg::CFG_CONTROL_PULSE) begin
        pulse_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_pending_r    <= 1'b0;
      open_elapsed_r    <= '0;
      stored_duration_r <= '0;
      span_r            <= '0;
      close_pending_r   <= 1'b0;
      close_elapsed_r   <= '0;
      pulse_active_r    <= 1'b0;
      pulse_elapsed_r   <= '0;
      open_flag_r       <= 1'b0;
      dl_r              <= '0;
    end else if (step) begin
      open_pending_r    <= open_pending_nxt;
      open_elapsed_r    <= open_elapsed_nxt;
      stored_duration_r <= stored_duration_nxt;
      span_r            <= span_nxt;
      close_pending_r   <= close_pending_nxt;
      close_elapsed_r   <= close_elapsed_nxt;
      pulse_active_r    <= pulse_active_nxt;
      pulse_elapsed_r   <= pulse_elapsed_nxt;
      open_flag_r       <= open_flag_nxt;
      dl_r              <= dl_nxt;
    end
  end

  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(dl_r[mvts_pkg::DL_OPEN_DRIVE] && dl_r[mvts_pkg::DL_CLOSE_DRIVE]))
    else $error("open and close lines driven together");

  a_drive_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (dl_r[mvts_pkg::DL_OPEN_DRIVE] || dl_r[mvts_pkg::DL_CLOSE_DRIVE]) |-> pulse_active_r)
    else $error("motor line driven without a running pulse timer");

  a_open_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    open_flag_r |-> (dl_r[mvts_pkg::DL_OPEN_LAMP] && !dl_r[mvts_pkg::DL_CLOSE_LAMP]))
    else $error("open flag set with lamps not showing open");

endmodule

@@ rtl/mvts_outq.sv @@
module mvts_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mvts_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mvts_pkg::result_t out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  mvts_pkg::result_t main_r, main_nxt;
  mvts_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty output register");

endmodule

@@ rtl/motor_valve_timed_sequencer.sv @@
// Motorized valve sequencer. Every accepted input word (1 ms tick, open with a
// duration in minutes, or close) yields exactly one result word carrying the
// drive lines, lamps, open flag and remaining time (ms while an open is pending,
// otherwise the stored duration in minutes). One word is taken per cycle while
// in_stall is low: the timers and checks are combinational and settle into the
// state registers, and a two-word output buffer lets input continue while a
// result is stalled. in_stall rises only when both output words are occupied.
// Configuration (index 0 reversal pause, index 1 pulse time) is always ready and
// should be written while the block is idle.
module motor_valve_timed_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [15:0]                    in_duration_minutes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_open_drive,
  output logic                           out_close_drive,
  output logic                           out_open_lamp,
  output logic                           out_close_lamp,
  output logic                           out_valve_is_open,
  output logic [31:0]                    out_remaining,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic              step;
  logic              full;
  mvts_pkg::result_t result;
  mvts_pkg::result_t out_word;

  assign in_stall  = full;
  assign step      = in_valid && !full;
  assign cfg_ready = 1'b1;

  mvts_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .command          (in_command),
    .duration_minutes (in_duration_minutes),
    .cfg_we           (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result           (result)
  );

  mvts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_word)
  );

  assign out_open_drive    = out_word.open_drive;
  assign out_close_drive   = out_word.close_drive;
  assign out_open_lamp     = out_word.open_lamp;
  assign out_close_lamp    = out_word.close_lamp;
  assign out_valve_is_open = out_word.valve_is_open;
  assign out_remaining     = out_word.remaining;

endmodule

@@ test/valve_result_checker.sv @@
`timescale 1ns / 100ps

module valve_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [15:0]                    in_duration_minutes,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_open_drive,
  input  logic                           out_close_drive,
  input  logic                           out_open_lamp,
  input  logic                           out_close_lamp,
  input  logic                           out_valve_is_open,
  input  logic [31:0]                    out_remaining,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             opened,
  output int                             closed
);

  logic [15:0] pause_ms;
  logic [15:0] pulse_len;

  logic        open_pend;
  logic [31:0] open_ms;
  logic [15:0] dur_store;
  logic        close_pend;
  logic [16:0] close_ms;
  logic        pulse_on;
  logic [16:0] pulse_ms;
  logic        valve_open;
  logic [3:0]  lines;

  mvts_pkg::result_t status_q[$];
  int                mism;
  int                seen;
  int                n_open;
  int                n_close;

  function automatic logic [63:0] open_span_ms();
    return {48'd0, dur_store} * {48'd0, mvts_pkg::TICKS_PER_MINUTE};
  endfunction

  task automatic shut_valve();
    lines      = mvts_pkg::DL_CLOSED;
    open_pend  = 1'b0;
    valve_open = 1'b0;
    pulse_on   = 1'b1;
    pulse_ms   = '0;
    n_close++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mism++;
      if (mism <= 10) begin
        $display("result %0d: %s expected %0d, got %0d", seen, name, exp_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    mvts_pkg::result_t want;
    logic [63:0]       span;
    logic [63:0]       left;
    if (!rst_n) begin
      pause_ms   = mvts_pkg::REVERSAL_PAUSE_RST;
      pulse_len  = mvts_pkg::CONTROL_PULSE_RST;
      open_pend  = 1'b0;
      open_ms    = '0;
      dur_store  = '0;
      close_pend = 1'b0;
      close_ms   = '0;
      pulse_on   = 1'b0;
      pulse_ms   = '0;
      valve_open = 1'b0;
      lines      = '0;
      status_q.delete();
      mism    = 0;
      seen    = 0;
      n_open  = 0;
      n_close = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (status_q.size() == 0) begin
          mism++;
          if (mism <= 10) begin
            $display("result %0d arrived with no word outstanding", seen);
          end
        end else begin
          want = status_q.pop_front();
          check_field("open_drive", 32'(want.open_drive), 32'(out_open_drive));
          check_field("close_drive", 32'(want.close_drive), 32'(out_close_drive));
          check_field("open_lamp", 32'(want.open_lamp), 32'(out_open_lamp));
          check_field("close_lamp", 32'(want.close_lamp), 32'(out_close_lamp));
          check_field("valve_is_open", 32'(want.valve_is_open), 32'(out_valve_is_open));
          check_field("remaining", want.remaining, out_remaining);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mvts_pkg::CFG_REVERSAL_PAUSE: pause_ms = cfg_data;
          mvts_pkg::CFG_CONTROL_PULSE:  pulse_len = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        case (in_command)
          mvts_pkg::CMD_TICK: begin
            if (open_pend && open_ms != mvts_pkg::MAX32) open_ms++;
            if (close_pend && close_ms != mvts_pkg::MAX17) close_ms++;
            if (pulse_on && pulse_ms != mvts_pkg::MAX17) pulse_ms++;
            if (open_pend && open_ms > pause_ms) begin
              if (!valve_open) begin
                lines      = mvts_pkg::DL_OPENED;
                valve_open = 1'b1;
                pulse_on   = 1'b1;
                pulse_ms   = '0;
                n_open++;
              end
              if ({32'd0, open_ms} > open_span_ms()) shut_valve();
            end
            if (close_pend && close_ms > pause_ms) begin
              close_pend = 1'b0;
              shut_valve();
            end
            if (pulse_on && pulse_ms > pulse_len) begin
              lines    = lines & ~mvts_pkg::DL_DRIVES;
              pulse_on = 1'b0;
            end
          end
          mvts_pkg::CMD_OPEN: begin
            lines     = lines & ~mvts_pkg::DL_DRIVES;
            open_pend = 1'b1;
            open_ms   = '0;
            dur_store = in_duration_minutes;
          end
          mvts_pkg::CMD_CLOSE: begin
            lines      = lines & ~mvts_pkg::DL_DRIVES;
            close_pend = 1'b1;
            close_ms   = '0;
          end
          default: ;
        endcase

        if (open_pend) begin
          span = open_span_ms();
          left = (span > {32'd0, open_ms}) ? span - {32'd0, open_ms} : 64'd0;
          if (left > {32'd0, mvts_pkg::MAX32}) left = {32'd0, mvts_pkg::MAX32};
          want.remaining = left[31:0];
        end else begin
          want.remaining = {16'd0, dur_store};
        end
        want.open_drive    = lines[mvts_pkg::DL_OPEN_DRIVE];
        want.close_drive   = lines[mvts_pkg::DL_CLOSE_DRIVE];
        want.open_lamp     = lines[mvts_pkg::DL_OPEN_LAMP];
        want.close_lamp    = lines[mvts_pkg::DL_CLOSE_LAMP];
        want.valve_is_open = valve_open;
        status_q.push_back(want);
      end
    end

    errors  <= mism;
    pending <= status_q.size();
    checked <= seen;
    opened  <= n_open;
    closed  <= n_close;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0]                     CMD_UNUSED = 2'd3;
  localparam logic [mvts_pkg::CFG_IDX_W-1:0] CFG_UNUSED = mvts_pkg::CFG_CONTROL_PULSE + 8'd1;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_command = mvts_pkg::CMD_TICK;
  logic [15:0]                    in_duration_minutes = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_open_drive;
  logic                           out_close_drive;
  logic                           out_open_lamp;
  logic                           out_close_lamp;
  logic                           out_valve_is_open;
  logic [31:0]                    out_remaining;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  int errors;
  int pending;
  int checked;
  int opened;
  int closed;

  int tx_pct = 0;
  int rx_pct = 0;
  int n_sent = 0;
  int n_cfg  = 0;

  motor_valve_timed_sequencer uut (.*);

  valve_result_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_pct);
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic [1:0] cmd, input logic [15:0] dur);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_duration_minutes <= dur;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic write_reg(input logic [mvts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  // drain all outstanding results, then wait with no traffic
  task automatic settle();
    int n;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < 5000);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [15:0] pause_v;
    logic [15:0] pulse_v;
    logic [1:0]  cmd;
    logic [15:0] dur;
    int          r;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(mvts_pkg::CFG_REVERSAL_PAUSE, 16'd2);
    write_reg(mvts_pkg::CFG_CONTROL_PULSE, 16'd3);
    write_reg(CFG_UNUSED, 16'hFFFF);

    send_word(mvts_pkg::CMD_TICK, 16'h0000);
    send_word(CMD_UNUSED, 16'hFFFF);
    // zero duration: opens and closes on the same tick
    send_word(mvts_pkg::CMD_OPEN, 16'h0000);
    repeat (7) send_word(mvts_pkg::CMD_TICK, 16'h0000);
    send_word(mvts_pkg::CMD_OPEN, 16'hFFFF);
    repeat (3) send_word(mvts_pkg::CMD_TICK, 16'hFFFF);
    // reopen while open, then a close that cancels the pending open
    send_word(mvts_pkg::CMD_OPEN, 16'h0001);
    send_word(mvts_pkg::CMD_CLOSE, 16'h0000);
    repeat (7) send_word(mvts_pkg::CMD_TICK, 16'h5555);
    send_word(mvts_pkg::CMD_CLOSE, 16'hFFFF);
    send_word(mvts_pkg::CMD_OPEN, 16'h8000);
    repeat (2) send_word(mvts_pkg::CMD_TICK, 16'hAAAA);
    in_valid <= 1'b0;
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin pause_v = 16'd3;     pulse_v = 16'd5;     end
        1: begin pause_v = 16'd0;     pulse_v = 16'd0;     end
        2: begin pause_v = 16'd0;     pulse_v = 16'hFFFF;  end
        3: begin pause_v = 16'hFFFF;  pulse_v = 16'd0;     end
        4: begin
          pause_v = 16'($urandom_range(1, 8));
          pulse_v = 16'($urandom_range(0, 12));
        end
        default: begin
          pause_v = 16'($urandom_range(0, 4));
          pulse_v = 16'($urandom_range(0, 6));
        end
      endcase
      write_reg(mvts_pkg::CFG_REVERSAL_PAUSE, pause_v);
      write_reg(mvts_pkg::CFG_CONTROL_PULSE, pulse_v);
      tx_pct = (ph < 2) ? 23 : (ph < 4) ? 57 : 0;
      rx_pct = (ph < 2) ? 57 : (ph < 4) ? 23 : 0;

      repeat (190) begin
        r   = $urandom_range(0, 99);
        dur = 16'($urandom);
        if (r < 78) begin
          cmd = mvts_pkg::CMD_TICK;
        end else if (r < 88) begin
          cmd = mvts_pkg::CMD_OPEN;
          r   = $urandom_range(0, 99);
          if (r < 60) dur = 16'd0;
          else if (r < 80) dur = 16'($urandom_range(1, 3));
        end else if (r < 97) begin
          cmd = mvts_pkg::CMD_CLOSE;
        end else begin
          cmd = CMD_UNUSED;
        end
        send_word(cmd, dur);
      end
      in_valid <= 1'b0;
      settle();
    end

    $display("Sent %0d words with %0d register writes; %0d results compared, %0d left over.",
             n_sent, n_cfg, checked, pending);
    $display("Valve opened %0d and closed %0d times across six timer settings.",
             opened, closed);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mvts_pkg.sv
rtl/mvts_core.sv
rtl/mvts_outq.sv
rtl/motor_valve_timed_sequencer.sv
test/valve_result_checker.sv
test/tb_top.sv
